// ===== sv/x87seu_pkg.sv =====
// ----------------------------------------------------------------------------
// x87seu_pkg
// Shared types and constants for the x87 stack and exception unit: item and
// result layouts, operation codes, status word bit positions.
// ----------------------------------------------------------------------------
package x87seu_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int TOP_W       = $clog2(STACK_DEPTH);

    // Status word bit positions
    localparam int SW_IE      = 0;
    localparam int SW_DE      = 1;
    localparam int SW_ZE      = 2;
    localparam int SW_OE      = 3;
    localparam int SW_UE      = 4;
    localparam int SW_PE      = 5;
    localparam int SW_SF      = 6;
    localparam int SW_ES      = 7;
    localparam int SW_C1      = 9;
    localparam int SW_TOP_LSB = 11;
    localparam int SW_B       = 15;

    localparam logic [9:0]  EXC_ALL    = 10'h27F;
    localparam logic [6:0]  UM_IE_ZE   = 7'h05;
    localparam logic [15:0] CW_RESET   = 16'h037F;

    // Operation codes
    localparam logic [2:0] MODE_PUSH  = 3'd0;
    localparam logic [2:0] MODE_POP   = 3'd1;
    localparam logic [2:0] MODE_MARK  = 3'd2;
    localparam logic [2:0] MODE_QUERY = 3'd3;
    localparam logic [2:0] MODE_RAISE = 3'd4;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] reg_index;
        logic       mark_empty;
        logic [9:0] exception_bits;
        logic       stack_overflow;
    } x87seu_item_t;

    typedef struct packed {
        logic [15:0]      status_out;
        logic [TOP_W-1:0] stack_top;
        logic             reg_empty;
        logic [6:0]       unmasked;
        logic             write_default_nan;
    } x87seu_result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } x87seu_cmd_t;

endpackage

// ===== sv/x87_stack_and_exception_unit_top.sv =====
// ----------------------------------------------------------------------------
// x87_stack_and_exception_unit_top
// x87 status word and register tag keeper: push, pop, tag mark, empty query
// and exception raise with sticky flags and unmasked reporting.
// ----------------------------------------------------------------------------
// Usage:
//   - Command channel: drive cmd and raise start; the transaction is taken at
//     the clock edge where start is high and busy is low.
//   - busy is high for the single execute cycle after a transaction is taken.
//   - Result channel: result_valid pulses for exactly one cycle, following
//     the execute state, with result holding status, TOP, query bit,
//     unmasked exceptions and the default-NaN request. The receiver cannot
//     stall, so sample result whenever result_valid is high.
//   - Pacing: a new transaction is taken only once the previous one has left
//     execute, set by the capture/execute sequence of the controller. A new
//     start may be issued in the same cycle a previous result is strobed.
//   - Configuration: cfg_wr_en/cfg_wr_data write the control word (exception
//     masks in bits 0-5); write only while no transaction is in flight.
//   - Reset: control word returns to 0x037F (all masked), status word and
//     all busy tags clear (every register empty, TOP = 0).
// ----------------------------------------------------------------------------
module x87_stack_and_exception_unit_top
    import x87seu_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  x87seu_item_t   cmd,
    input  logic           cfg_wr_en,
    input  logic [15:0]    cfg_wr_data,
    output logic           result_valid,
    output x87seu_result_t result
);

    // Command bus from sequencer to datapath
    x87seu_cmd_t dp_cmd;

    x87seu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (dp_cmd)
    );

    // Holds architectural state; status word and tags update only on execute, the control word on cfg_wr_en
    x87seu_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .item        (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result)
    );

endmodule

// ===== sv/x87seu_datapath.sv =====
// ----------------------------------------------------------------------------
// x87seu_datapath
// Control word, status word and busy tags; evaluates one operation per
// execute command and registers the result.
// ----------------------------------------------------------------------------
module x87seu_datapath
    import x87seu_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  x87seu_cmd_t    cmd,
    input  x87seu_item_t   item,
    input  logic           cfg_wr_en,
    input  logic [15:0]    cfg_wr_data,
    output x87seu_result_t result
);

    logic [15:0]            cw_reg;
    logic [15:0]            sw_reg;
    logic [15:0]            sw_next;
    logic [STACK_DEPTH-1:0] tags_reg;
    logic [STACK_DEPTH-1:0] tags_next;
    x87seu_item_t           item_reg;
    x87seu_result_t         result_reg;
    x87seu_result_t         result_next;

    logic [TOP_W-1:0] top_cur;
    logic [TOP_W-1:0] top_new;
    logic [TOP_W-1:0] phys;
    logic [9:0]       exc;
    logic [6:0]       um;
    logic             empty;
    logic             nan;
    logic             fin;

    always_comb
    begin
        top_cur   = sw_reg[SW_TOP_LSB +: TOP_W];
        top_new   = top_cur - 1'b1;
        phys      = top_cur + item_reg.reg_index;
        exc       = item_reg.exception_bits & EXC_ALL;
        sw_next   = sw_reg;
        tags_next = tags_reg;
        empty     = 1'b0;
        um        = '0;
        nan       = 1'b0;
        fin       = 1'b0;

        case (item_reg.mode)
            MODE_PUSH:
            begin
                sw_next[SW_TOP_LSB +: TOP_W] = top_new;
            end
            MODE_POP:
            begin
                tags_next[top_cur] = 1'b0;
                sw_next[SW_TOP_LSB +: TOP_W] = top_cur + 1'b1;
            end
            MODE_MARK:
            begin
                tags_next[phys] = ~item_reg.mark_empty;
            end
            MODE_QUERY:
            begin
                empty = ~tags_reg[phys];
            end
            MODE_RAISE:
            begin
                // Overflow with invalid masked: push and load the default NaN
                if (item_reg.stack_overflow && cw_reg[SW_IE])
                begin
                    sw_next[SW_TOP_LSB +: TOP_W] = top_new;
                    tags_next[top_new] = 1'b1;
                    nan = 1'b1;
                end
                um = {1'b0, exc[5:0] & ~cw_reg[5:0]};
                if (exc[SW_IE] || exc[SW_ZE])
                    um = um & UM_IE_ZE;
                if (|um)
                begin
                    sw_next[SW_ES] = 1'b1;
                    sw_next[SW_B]  = 1'b1;
                end
                if (exc[SW_IE])
                begin
                    sw_next = sw_next | {6'b0, exc};
                    if (exc[SW_SF] && !exc[SW_C1])
                        sw_next[SW_C1] = 1'b0;
                    fin = 1'b1;
                end
                else if (exc[SW_ZE])
                begin
                    sw_next[SW_ZE] = 1'b1;
                    fin = 1'b1;
                end
                // Unmasked denormal alone stops after sticking DE
                if (!fin && exc[SW_DE])
                begin
                    sw_next[SW_DE] = 1'b1;
                    if (um[SW_DE])
                        fin = 1'b1;
                end
                if (!fin)
                begin
                    sw_next = sw_next | {6'b0, exc};
                    if (exc[SW_PE] && !exc[SW_C1])
                        sw_next[SW_C1] = 1'b0;
                    um[SW_PE] = 1'b0;
                    if (um[SW_UE] || um[SW_OE])
                    begin
                        sw_next[SW_C1] = 1'b0;
                        if (!sw_reg[SW_PE])
                            sw_next[SW_PE] = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        result_next.status_out        = sw_next;
        result_next.stack_top         = sw_next[SW_TOP_LSB +: TOP_W];
        result_next.reg_empty         = empty;
        result_next.unmasked          = um;
        result_next.write_default_nan = nan;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg   <= CW_RESET;
            sw_reg   <= '0;
            tags_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                cw_reg <= cfg_wr_data;
            if (cmd.execute)
            begin
                sw_reg   <= sw_next;
                tags_reg <= tags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= item;
        if (cmd.execute)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ===== sv/x87seu_ctrl.sv =====
// ----------------------------------------------------------------------------
// x87seu_ctrl
// Sequencer: capture a transaction, execute it for one cycle, strobe the
// result in the following cycle.
// ----------------------------------------------------------------------------
module x87seu_ctrl
    import x87seu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        result_valid,
    output x87seu_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    always_comb
    begin
        cmd.capture       = (state_reg == ST_IDLE) && start;
        cmd.execute       = (state_reg == ST_EXEC);
        result_valid_next = cmd.execute;
        case (state_reg)
            ST_IDLE: state_next = start ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign busy         = (state_reg == ST_EXEC);
    assign result_valid = result_valid_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> busy)
        else $error("accepted transaction did not enter execute");

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && result_valid))
        else $error("execute did not finish with a result strobe");

    a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without a preceding execute");

endmodule
